// ----- src/ogpt_pkg.sv -----
// shared types, constants and register codes for the grid point to tile unit
`timescale 1ns / 1ps
`default_nettype none
package ogpt_pkg;

  // coordinate width of points and tile indices
  localparam int CoordBits = 16;
  // every register holds two 16-bit halves
  localparam int HalfBits = 16;
  localparam int CfgBits = 32;
  localparam int CfgIdxBits = 3;
  // quotient magnitude width of the floor divider
  localparam int QuotBits = (CoordBits > HalfBits) ? CoordBits : HalfBits;

  typedef enum logic [CfgIdxBits-1:0] {
    CfgGridOrigin,
    CfgTileSize,
    CfgTileStep,
    CfgOddRowShift,
    CfgOddColumnShift,
    CfgTileCenter
  } cfg_idx_e;

  localparam logic [CfgBits-1:0] GridOriginRst = 32'h0000_0000;
  localparam logic [CfgBits-1:0] TileSizeRst = 32'h0010_0010;
  localparam logic [CfgBits-1:0] TileStepRst = 32'h0010_0010;
  localparam logic [CfgBits-1:0] OddRowShiftRst = 32'h0000_0000;
  localparam logic [CfgBits-1:0] OddColumnShiftRst = 32'h0000_0000;
  localparam logic [CfgBits-1:0] TileCenterRst = 32'h0008_0008;

  typedef struct packed {
    logic signed [CoordBits-1:0] point_x;
    logic signed [CoordBits-1:0] point_y;
  } point_t;

  typedef struct packed {
    logic signed [CoordBits-1:0] column;
    logic signed [CoordBits-1:0] row;
  } tile_t;

endpackage
`default_nettype wire

// ----- src/ogpt_floor_div.sv -----
// two-lane pipelined floor divider, one quotient bit per stage, with payload
`timescale 1ns / 1ps
`default_nettype none
module ogpt_floor_div #(
  parameter int QW = 16,
  parameter int PayBits = 32
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  valid_i,
  input  wire logic [1:0][QW:0]                      num_i,
  input  wire logic [1:0][ogpt_pkg::HalfBits-1:0]    den_i,
  input  wire logic [PayBits-1:0]                    pay_i,
  output logic                                       valid_o,
  output logic [1:0][QW:0]                           quot_o,
  output logic [PayBits-1:0]                         pay_o
);
  import ogpt_pkg::*;

  localparam int AccW = HalfBits + QW;

  logic               vld_q [QW];
  logic [PayBits-1:0] pay_q [QW];
  logic [1:0]         neg_q [QW];
  logic [AccW-1:0]    acc_q [QW][2];
  logic [AccW-1:0]    acc_d [QW][2];

  // one restoring step per stage and lane
  for (genvar k = 0; k < QW; k++) begin : g_stage
    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [AccW-1:0]   src;
      logic [HalfBits:0] top;
      logic [HalfBits:0] diff;
      logic              ge;
      logic [HalfBits-1:0] rem;
      if (k == 0) begin : g_first
        // floor of a negative numerator: divide its complement, complement back
        assign src = {{HalfBits{1'b0}},
                      (num_i[l][QW] ? ~num_i[l][QW-1:0] : num_i[l][QW-1:0])};
      end else begin : g_next
        assign src = acc_q[k-1][l];
      end
      assign top  = src[AccW-1:QW-1];
      assign diff = top - {1'b0, den_i[l]};
      assign ge   = (top >= {1'b0, den_i[l]});
      assign rem  = ge ? diff[HalfBits-1:0] : top[HalfBits-1:0];
      assign acc_d[k][l] = {rem, src[QW-2:0], ge};
    end

    // stage registers
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= (k == 0) ? valid_i : vld_q[(k == 0) ? 0 : k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      acc_q[k][0] <= acc_d[k][0];
      acc_q[k][1] <= acc_d[k][1];
      if (k == 0) begin
        pay_q[k] <= pay_i;
        neg_q[k] <= {num_i[1][QW], num_i[0][QW]};
      end else begin
        pay_q[k] <= pay_q[(k == 0) ? 0 : k-1];
        neg_q[k] <= neg_q[(k == 0) ? 0 : k-1];
      end
    end
  end

  // restore the sign of the floor quotient
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      quot_o[l] = neg_q[QW-1][l] ? ~{1'b0, acc_q[QW-1][l][QW-1:0]}
                                 : {1'b0, acc_q[QW-1][l][QW-1:0]};
    end
  end

  assign valid_o = vld_q[QW-1];
  assign pay_o   = pay_q[QW-1];

endmodule
`default_nettype wire

// ----- src/offset_grid_point_to_tile_unit.sv -----
// top level: maps a signed canvas point to the tile of an offset grid
`timescale 1ns / 1ps
`default_nettype none
// Usage
//   Input: a point word (point_x, point_y) is taken at each rising edge with
//   start high and busy low. busy is always low: a new point may be given
//   in every cycle, so one word per cycle is sustained.
//   Output: each point gives one tile word (column, row) on result_o, shown
//   for exactly one cycle with result_valid_o high, in input order.
//   Pipeline: an input register, then the floor divider, one quotient bit
//   per stage, followed by the multiply, neighbour offset, saturate,
//   square, sum and four-level minimum tree stages and the output register.
//   Configuration: cfg_we_i writes cfg_wdata_i into register cfg_idx_i at
//   the edge; write only while no point is in flight.
//   Reset: clears all valid bits and loads the register reset values; no
//   word is lost at the output since the receiver cannot stall.
module offset_grid_point_to_tile_unit (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire ogpt_pkg::point_t                  point_i,
  input  wire logic                              cfg_we_i,
  input  wire logic [ogpt_pkg::CfgIdxBits-1:0]   cfg_idx_i,
  input  wire logic [ogpt_pkg::CfgBits-1:0]      cfg_wdata_i,
  output logic                                   result_valid_o,
  output ogpt_pkg::tile_t                        result_o
);
  import ogpt_pkg::*;

  localparam int QW = QuotBits;
  localparam int CB = CoordBits;
  localparam int HB = HalfBits;
  localparam int PW = QW + HB + 1;   // index times step
  localparam int AW = PW + 3;        // corner minus point
  localparam int DW = AW + 1;        // with both shifts
  localparam int MagBits = 31;
  localparam int SqBits = 2 * MagBits;
  localparam int DistBits = SqBits + 1;
  localparam int NumPost = 9;
  localparam logic signed [DW-1:0] SatPos = DW'(64'sd2147483647);
  localparam logic signed [DW-1:0] SatNeg = -SatPos;

  typedef struct packed {
    logic signed [QW:0]   col;
    logic signed [QW:0]   row;
    logic signed [CB-1:0] px;
    logic signed [CB-1:0] py;
  } ctx_t;

  typedef struct packed {
    logic [DistBits-1:0] sq_dist;
    logic [3:0]          idx;
  } cand_t;

  // configuration registers
  logic [CfgBits-1:0] origin_q, size_q, step_q, row_sh_q, col_sh_q, center_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_q <= GridOriginRst;
      size_q   <= TileSizeRst;
      step_q   <= TileStepRst;
      row_sh_q <= OddRowShiftRst;
      col_sh_q <= OddColumnShiftRst;
      center_q <= TileCenterRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgGridOrigin:     origin_q <= cfg_wdata_i;
        CfgTileSize:       size_q   <= cfg_wdata_i;
        CfgTileStep:       step_q   <= cfg_wdata_i;
        CfgOddRowShift:    row_sh_q <= cfg_wdata_i;
        CfgOddColumnShift: col_sh_q <= cfg_wdata_i;
        CfgTileCenter:     center_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // signed halves of the registers
  logic signed [HB-1:0] ox, oy, sx, sy, rsx, rsy, csx, csy, cx, cy;
  logic                 zero_tile, use_search;
  assign ox  = origin_q[HB-1:0];
  assign oy  = origin_q[2*HB-1:HB];
  assign sx  = step_q[HB-1:0];
  assign sy  = step_q[2*HB-1:HB];
  assign rsx = row_sh_q[HB-1:0];
  assign rsy = row_sh_q[2*HB-1:HB];
  assign csx = col_sh_q[HB-1:0];
  assign csy = col_sh_q[2*HB-1:HB];
  assign cx  = center_q[HB-1:0];
  assign cy  = center_q[2*HB-1:HB];
  assign zero_tile  = (size_q[HB-1:0] == '0) || (size_q[2*HB-1:HB] == '0);
  assign use_search = (row_sh_q != '0) || (col_sh_q != '0);

  assign busy = 1'b0;

  // input stage: numerators point minus origin
  logic              in_vld_q;
  logic [1:0][QW:0]  num_q;
  point_t            pt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= start;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q[0] <= (QW+1)'(point_i.point_x) - (QW+1)'(ox);
    num_q[1] <= (QW+1)'(point_i.point_y) - (QW+1)'(oy);
    pt_q     <= point_i;
  end

  // floor division by the tile size
  logic                       div_vld;
  logic [1:0][QW:0]           quot;
  logic [2*CB-1:0]            div_pay;
  logic [1:0][HB-1:0]         den;
  point_t                     div_pt;
  assign den[0] = size_q[HB-1:0];
  assign den[1] = size_q[2*HB-1:HB];
  assign div_pt = point_t'(div_pay);

  ogpt_floor_div #(
    .QW      (QW),
    .PayBits (2 * CB)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_vld_q),
    .num_i   (num_q),
    .den_i   (den),
    .pay_i   (pt_q),
    .valid_o (div_vld),
    .quot_o  (quot),
    .pay_o   (div_pay)
  );

  // context and valid line through the search stages
  logic vld_q [NumPost];
  ctx_t ctx_q [NumPost];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NumPost; s++) vld_q[s] <= 1'b0;
    end else begin
      vld_q[0] <= div_vld;
      for (int s = 1; s < NumPost; s++) vld_q[s] <= vld_q[s-1];
    end
  end

  always_ff @(posedge clk_i) begin
    ctx_q[0] <= '{col: quot[0], row: quot[1], px: div_pt.point_x, py: div_pt.point_y};
    for (int s = 1; s < NumPost; s++) ctx_q[s] <= ctx_q[s-1];
  end

  // stage 1: estimate index times step
  logic signed [PW-1:0] bx_q, by_q;
  always_ff @(posedge clk_i) begin
    bx_q <= $signed(quot[0]) * sx;
    by_q <= $signed(quot[1]) * sy;
  end

  // stage 2: corner plus center minus point for the four column and row offsets
  logic signed [AW-1:0] ax_q [4];
  logic signed [AW-1:0] ay_q [4];
  always_ff @(posedge clk_i) begin
    logic signed [AW-1:0] bsx, bsy, tx, ty;
    bsx = AW'(bx_q) + AW'(ox) + AW'(cx) - AW'(ctx_q[0].px);
    bsy = AW'(by_q) + AW'(oy) + AW'(cy) - AW'(ctx_q[0].py);
    for (int i = 0; i < 4; i++) begin
      case (i)
        0: begin tx = -AW'(sx); ty = -AW'(sy); end
        1: begin tx = '0; ty = '0; end
        2: begin tx = AW'(sx); ty = AW'(sy); end
        default: begin tx = AW'(sx) <<< 1; ty = AW'(sy) <<< 1; end
      endcase
      ax_q[i] <= bsx + tx;
      ay_q[i] <= bsy + ty;
    end
  end

  // stage 3: add parity shifts, saturate, take magnitude
  // mx[i][p]: column offset i, candidate row parity p
  // my[j][q]: row offset j, candidate column parity q
  logic [MagBits-1:0] mx_q [4][2];
  logic [MagBits-1:0] my_q [4][2];

  function automatic logic [MagBits-1:0] sat_mag(input logic signed [DW-1:0] v);
    logic signed [DW-1:0] s;
    logic signed [DW-1:0] m;
    s = (v > SatPos) ? SatPos : ((v < SatNeg) ? SatNeg : v);
    m = s[DW-1] ? -s : s;
    return m[MagBits-1:0];
  endfunction

  always_ff @(posedge clk_i) begin
    logic codd, rodd;
    logic signed [DW-1:0] vx, vy;
    for (int i = 0; i < 4; i++) begin
      // offset -1 and +1 flip the parity of the estimate
      codd = ctx_q[1].col[0] ^ (i % 2 == 0);
      rodd = ctx_q[1].row[0] ^ (i % 2 == 0);
      for (int p = 0; p < 2; p++) begin
        vx = DW'(ax_q[i]) + ((p == 1) ? DW'(rsx) : '0) + (codd ? DW'(csx) : '0);
        vy = DW'(ay_q[i]) + (rodd ? DW'(rsy) : '0) + ((p == 1) ? DW'(csy) : '0);
        mx_q[i][p] <= sat_mag(vx);
        my_q[i][p] <= sat_mag(vy);
      end
    end
  end

  // stage 4: squares
  logic [SqBits-1:0] qx_q [4][2];
  logic [SqBits-1:0] qy_q [4][2];
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 4; i++) begin
      for (int p = 0; p < 2; p++) begin
        qx_q[i][p] <= mx_q[i][p] * mx_q[i][p];
        qy_q[i][p] <= my_q[i][p] * my_q[i][p];
      end
    end
  end

  // stage 5: squared distance of each of the sixteen neighbours, row-major
  logic [DistBits-1:0] dist_q [16];
  always_ff @(posedge clk_i) begin
    logic pr, pc;
    for (int j = 0; j < 4; j++) begin
      for (int i = 0; i < 4; i++) begin
        pr = ctx_q[3].row[0] ^ (j % 2 == 0);
        pc = ctx_q[3].col[0] ^ (i % 2 == 0);
        dist_q[j*4+i] <= DistBits'(qx_q[i][pr]) + DistBits'(qy_q[j][pc]);
      end
    end
  end

  // stages 6 to 9: minimum tree, the earlier candidate wins a tie
  function automatic cand_t pick(input cand_t a, input cand_t b);
    return (b.sq_dist < a.sq_dist) ? b : a;
  endfunction

  cand_t l1_q [8];
  cand_t l2_q [4];
  cand_t l3_q [2];
  cand_t best_q;

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 8; k++) begin
      l1_q[k] <= pick('{sq_dist: dist_q[2*k],   idx: 4'(2*k)},
                      '{sq_dist: dist_q[2*k+1], idx: 4'(2*k+1)});
    end
    for (int k = 0; k < 4; k++) l2_q[k] <= pick(l1_q[2*k], l1_q[2*k+1]);
    for (int k = 0; k < 2; k++) l3_q[k] <= pick(l2_q[2*k], l2_q[2*k+1]);
    best_q <= pick(l3_q[0], l3_q[1]);
  end

  // output stage: choose pass-through, estimate or nearest neighbour
  logic              out_vld_q;
  tile_t             out_q;
  logic [QW+1:0]     sel_col, sel_row;

  assign sel_col = (QW+2)'(ctx_q[8].col) + (QW+2)'(best_q.idx[1:0]) - (QW+2)'(1);
  assign sel_row = (QW+2)'(ctx_q[8].row) + (QW+2)'(best_q.idx[3:2]) - (QW+2)'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= vld_q[8];
    end
  end

  always_ff @(posedge clk_i) begin
    if (zero_tile) begin
      out_q.column <= ctx_q[8].px;
      out_q.row    <= ctx_q[8].py;
    end else if (use_search) begin
      out_q.column <= sel_col[CB-1:0];
      out_q.row    <= sel_row[CB-1:0];
    end else begin
      out_q.column <= ctx_q[8].col[CB-1:0];
      out_q.row    <= ctx_q[8].row[CB-1:0];
    end
  end

  assign result_valid_o = out_vld_q;
  assign result_o       = out_q;

endmodule
`default_nettype wire
